// File: rtl/core/lkvc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkvc_pkg
// Shared types and codes for the LRU key-value cache core.
// ----------------------------------------------------------------------------
package lkvc_pkg;

   localparam logic CMD_GET = 1'b0;
   localparam logic CMD_PUT = 1'b1;

   localparam logic [31:0] MISS_VALUE = 32'hFFFF_FFFF;

   localparam int      CSR_AW          = 2;
   localparam logic [CSR_AW-1:0] CSR_ADDR_CAPACITY = 2'd0;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_DECIDE,
      ST_UPDATE,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic rd_en;
      logic kv_we;
      logic rank_we;
   } store_ctl_type;

endpackage

// File: rtl/core/lkvc_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkvc_store
// Entry storage: key, value and recency-rank memories with one registered
// read port shared by all three, a key/value write port and a rank write port.
// ----------------------------------------------------------------------------
module lkvc_store #(
   parameter int CAPACITY = 16
) (
   input  logic                                          clock,
   input  lkvc_pkg::store_ctl_type                       ctl,
   input  logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] rd_addr,
   input  logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] kv_addr,
   input  logic [31:0]                                   kv_key,
   input  logic [31:0]                                   kv_value,
   input  logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] rank_addr,
   input  logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] rank_wdata,
   output logic [31:0]                                   rd_key,
   output logic [31:0]                                   rd_value,
   output logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] rd_rank
);

   localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

   logic [31:0]   key_mem  [CAPACITY];
   logic [31:0]   val_mem  [CAPACITY];
   logic [IW-1:0] rank_mem [CAPACITY];

   logic [31:0]   key_rd_ff;
   logic [31:0]   val_rd_ff;
   logic [IW-1:0] rank_rd_ff;

   always_ff @(posedge clock) begin
      if (ctl.kv_we) begin
         key_mem[kv_addr] <= kv_key;
         val_mem[kv_addr] <= kv_value;
      end
      if (ctl.rd_en) begin
         key_rd_ff <= key_mem[rd_addr];
         val_rd_ff <= val_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.rank_we) begin
         rank_mem[rank_addr] <= rank_wdata;
      end
      if (ctl.rd_en) begin
         rank_rd_ff <= rank_mem[rd_addr];
      end
   end

   assign rd_key   = key_rd_ff;
   assign rd_value = val_rd_ff;
   assign rd_rank  = rank_rd_ff;

endmodule

// File: rtl/core/lru_key_value_cache_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_key_value_cache_core
// Fully associative key-value cache with least-recently-used replacement.
//
// Usage:
//   Requests enter on req_* (valid/ready): command 0 is a get, 1 is a put.
//   A get produces one response on rsp_* (hit flag and value, -1 on miss);
//   a put produces none. Requests are handled one at a time; req_ready is
//   high only while the core is idle.
//   A request scans the entry memories one entry per cycle through a single
//   registered read port: a search pass, then for hits and puts a rank update
//   pass. A response waits in an output register; a stalled receiver holds a
//   get in the core's final step until the response slot frees.
//   Reset empties the cache (valid bits cleared, count zero) and sets
//   active_capacity to 16; no clearing pass is needed.
//   active_capacity (APB, address 0) limits entries held before evicting.
// ----------------------------------------------------------------------------
module lru_key_value_cache_core #(
   parameter int CAPACITY = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_command,
   input  logic signed [31:0]            req_key,
   input  logic signed [31:0]            req_value,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_hit,
   output logic signed [31:0]            rsp_read_value,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [lkvc_pkg::CSR_AW-1:0]   paddr,
   input  logic [31:0]                   pwdata,
   output logic [31:0]                   prdata,
   output logic                          pready
);

   localparam int IW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW   = $clog2(CAPACITY + 1);
   localparam int CMPW = (CW > 5) ? CW : 5;
   localparam logic [IW-1:0]   LAST_IDX = IW'(CAPACITY - 1);
   localparam logic [CMPW-1:0] CAP_MAX  = CMPW'(CAPACITY);

   lkvc_pkg::state_type state_ff, state_in;

   logic                cmd_ff, cmd_in;
   logic [31:0]         key_ff, key_in;
   logic [31:0]         value_ff, value_in;
   logic [IW-1:0]       addr_ff, addr_in;
   logic                issue_ff, issue_in;
   logic                pvld_ff, pvld_in;
   logic [IW-1:0]       pidx_ff, pidx_in;
   logic                found_ff, found_in;
   logic [IW-1:0]       hit_idx_ff, hit_idx_in;
   logic [IW-1:0]       hit_rank_ff, hit_rank_in;
   logic [31:0]         hit_val_ff, hit_val_in;
   logic [IW-1:0]       free_idx_ff, free_idx_in;
   logic [IW-1:0]       lru_idx_ff, lru_idx_in;
   logic [IW-1:0]       tgt_idx_ff, tgt_idx_in;
   logic [IW-1:0]       tgt_rank_ff, tgt_rank_in;
   logic                upd_ff, upd_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [CAPACITY-1:0] valid_ff, valid_in;
   logic [4:0]          cap_ff, cap_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_hit_ff, rsp_hit_in;
   logic [31:0]         rsp_value_ff, rsp_value_in;

   lkvc_pkg::store_ctl_type store_ctl;
   logic [31:0]   rd_key;
   logic [31:0]   rd_value;
   logic [IW-1:0] rd_rank;
   logic [IW-1:0] rank_wdata;
   logic [31:0]   kv_value;

   logic [CMPW-1:0] cap_ext;
   logic [CMPW-1:0] eff_cap;
   logic            full;
   logic [IW-1:0]   lru_rank;
   logic            cur_valid;
   logic            csr_write;
   logic            fin_go;

   lkvc_store #(
      .CAPACITY (CAPACITY)
   ) u_store (
      .clock      (clock),
      .ctl        (store_ctl),
      .rd_addr    (addr_ff),
      .kv_addr    (tgt_idx_ff),
      .kv_key     (key_ff),
      .kv_value   (kv_value),
      .rank_addr  (pidx_ff),
      .rank_wdata (rank_wdata),
      .rd_key     (rd_key),
      .rd_value   (rd_value),
      .rd_rank    (rd_rank)
   );

   assign cap_ext   = CMPW'(cap_ff);
   assign eff_cap   = (cap_ext == '0) ? CMPW'(1) :
                      ((cap_ext > CAP_MAX) ? CAP_MAX : cap_ext);
   assign full      = (CMPW'(count_ff) >= eff_cap);
   assign lru_rank  = IW'(count_ff - CW'(1));
   assign cur_valid = valid_ff[pidx_ff];
   assign kv_value  = (cmd_ff == lkvc_pkg::CMD_PUT) ? value_ff : hit_val_ff;
   assign csr_write = psel && penable && pwrite && (paddr == lkvc_pkg::CSR_ADDR_CAPACITY);
   assign fin_go    = (cmd_ff == lkvc_pkg::CMD_PUT) || !rsp_valid_ff || rsp_ready;

   assign req_ready      = (state_ff == lkvc_pkg::ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hit        = rsp_hit_ff;
   assign rsp_read_value = rsp_value_ff;
   assign pready         = 1'b1;
   assign prdata         = (paddr == lkvc_pkg::CSR_ADDR_CAPACITY) ? {27'd0, cap_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lkvc_pkg::ST_IDLE;
         issue_ff     <= 1'b0;
         pvld_ff      <= 1'b0;
         count_ff     <= '0;
         valid_ff     <= '0;
         cap_ff       <= 5'd16;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         issue_ff     <= issue_in;
         pvld_ff      <= pvld_in;
         count_ff     <= count_in;
         valid_ff     <= valid_in;
         cap_ff       <= cap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      key_ff       <= key_in;
      value_ff     <= value_in;
      addr_ff      <= addr_in;
      pidx_ff      <= pidx_in;
      found_ff     <= found_in;
      hit_idx_ff   <= hit_idx_in;
      hit_rank_ff  <= hit_rank_in;
      hit_val_ff   <= hit_val_in;
      free_idx_ff  <= free_idx_in;
      lru_idx_ff   <= lru_idx_in;
      tgt_idx_ff   <= tgt_idx_in;
      tgt_rank_ff  <= tgt_rank_in;
      upd_ff       <= upd_in;
      rsp_hit_ff   <= rsp_hit_in;
      rsp_value_ff <= rsp_value_in;
   end

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      key_in       = key_ff;
      value_in     = value_ff;
      addr_in      = addr_ff;
      issue_in     = issue_ff;
      pvld_in      = 1'b0;
      pidx_in      = pidx_ff;
      found_in     = found_ff;
      hit_idx_in   = hit_idx_ff;
      hit_rank_in  = hit_rank_ff;
      hit_val_in   = hit_val_ff;
      free_idx_in  = free_idx_ff;
      lru_idx_in   = lru_idx_ff;
      tgt_idx_in   = tgt_idx_ff;
      tgt_rank_in  = tgt_rank_ff;
      upd_in       = upd_ff;
      count_in     = count_ff;
      valid_in     = valid_ff;
      cap_in       = cap_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_hit_in   = rsp_hit_ff;
      rsp_value_in = rsp_value_ff;
      store_ctl    = '0;
      rank_wdata   = '0;

      if (csr_write) begin
         cap_in = pwdata[4:0];
      end

      // drain response slot
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      // advance scan address, one entry per cycle
      if (issue_ff) begin
         store_ctl.rd_en = 1'b1;
         pvld_in         = 1'b1;
         pidx_in         = addr_ff;
         if (addr_ff == LAST_IDX) begin
            issue_in = 1'b0;
         end else begin
            addr_in = addr_ff + IW'(1);
         end
      end

      unique case (state_ff)
         lkvc_pkg::ST_IDLE: begin
            if (req_valid) begin
               cmd_in   = req_command;
               key_in   = req_key;
               value_in = req_value;
               found_in = 1'b0;
               addr_in  = '0;
               issue_in = 1'b1;
               state_in = lkvc_pkg::ST_SEARCH;
            end
         end
         lkvc_pkg::ST_SEARCH: begin
            if (pvld_ff) begin
               if (cur_valid && (rd_key == key_ff)) begin
                  found_in    = 1'b1;
                  hit_idx_in  = pidx_ff;
                  hit_rank_in = rd_rank;
                  hit_val_in  = rd_value;
               end
               if (!cur_valid) begin
                  free_idx_in = pidx_ff;
               end
               if (cur_valid && (rd_rank == lru_rank)) begin
                  lru_idx_in = pidx_ff;
               end
               if (pidx_ff == LAST_IDX) begin
                  state_in = lkvc_pkg::ST_DECIDE;
               end
            end
         end
         lkvc_pkg::ST_DECIDE: begin
            if ((cmd_ff == lkvc_pkg::CMD_GET) && !found_ff) begin
               upd_in   = 1'b0;
               state_in = lkvc_pkg::ST_FINISH;
            end else begin
               upd_in = 1'b1;
               if (found_ff) begin
                  tgt_idx_in  = hit_idx_ff;
                  tgt_rank_in = hit_rank_ff;
               end else if (full) begin
                  tgt_idx_in  = lru_idx_ff;
                  tgt_rank_in = lru_rank;
               end else begin
                  tgt_idx_in  = free_idx_ff;
                  tgt_rank_in = IW'(count_ff);
                  count_in    = count_ff + CW'(1);
               end
               addr_in  = '0;
               issue_in = 1'b1;
               state_in = lkvc_pkg::ST_UPDATE;
            end
         end
         lkvc_pkg::ST_UPDATE: begin
            if (pvld_ff) begin
               if (pidx_ff == tgt_idx_ff) begin
                  store_ctl.rank_we = 1'b1;
                  rank_wdata        = '0;
               end else if (cur_valid && (rd_rank < tgt_rank_ff)) begin
                  store_ctl.rank_we = 1'b1;
                  rank_wdata        = rd_rank + IW'(1);
               end
               if (pidx_ff == LAST_IDX) begin
                  state_in = lkvc_pkg::ST_FINISH;
               end
            end
         end
         lkvc_pkg::ST_FINISH: begin
            if (fin_go) begin
               if (upd_ff) begin
                  store_ctl.kv_we      = 1'b1;
                  valid_in[tgt_idx_ff] = 1'b1;
               end
               if (cmd_ff == lkvc_pkg::CMD_GET) begin
                  rsp_valid_in = 1'b1;
                  rsp_hit_in   = found_ff;
                  rsp_value_in = found_ff ? hit_val_ff : lkvc_pkg::MISS_VALUE;
               end
               state_in = lkvc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = lkvc_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// File: tb/sv/tb_lru_key_value_cache_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lru_key_value_cache_core
// Self-checking bench for the LRU key-value cache core. A directed table
// covers extreme keys and values, updates, misses and capacity corners.
// Random phases follow, each with its own capacity setting and a small key
// pool so that hits, updates and evictions are frequent; both channels idle
// at random. Gets are checked by typed table rows or the bench's LRU predictor.
// ----------------------------------------------------------------------------
module tb_lru_key_value_cache_core;

   localparam int CACHE_DEPTH  = 16;
   localparam int DRAIN_CYCLES = 2 * CACHE_DEPTH + 12;
   localparam int PHASE_ITEMS  = 130;
   localparam int POOL_SIZE    = 24;
   localparam int N_DIRECTED   = 24;
   localparam int N_PHASES     = 10;

   typedef enum logic { ROW_REQ, ROW_CFG } row_kind_type;

   typedef struct packed {
      logic        hit;
      logic [31:0] value;
   } lookup_result_type;

   typedef struct packed {
      row_kind_type kind;
      logic         command;
      logic [31:0]  key;
      logic [31:0]  value;
      logic         typed;
      logic         exp_hit;
      logic [31:0]  exp_value;
   } directed_row_type;

   logic                        clock          = 1'b0;
   logic                        reset          = 1'b1;
   logic                        req_valid      = 1'b0;
   logic                        req_ready;
   logic                        req_command    = lkvc_pkg::CMD_GET;
   logic signed [31:0]          req_key        = '0;
   logic signed [31:0]          req_value      = '0;
   logic                        rsp_valid;
   logic                        rsp_ready      = 1'b0;
   logic                        rsp_hit;
   logic signed [31:0]          rsp_read_value;
   logic                        psel           = 1'b0;
   logic                        penable        = 1'b0;
   logic                        pwrite         = 1'b0;
   logic [lkvc_pkg::CSR_AW-1:0] paddr          = '0;
   logic [31:0]                 pwdata         = '0;
   logic [31:0]                 prdata;
   logic                        pready;

   lru_key_value_cache_core #(.CAPACITY(CACHE_DEPTH)) dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_command(req_command),
      .req_key(req_key), .req_value(req_value),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_hit(rsp_hit),
      .rsp_read_value(rsp_read_value),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #8_000_000;
      $display("TEST FAILED");
      $finish;
   end

   // ---------------------------------------------------------------- predictor
   logic [31:0]       cache_key  [CACHE_DEPTH];
   logic [31:0]       cache_data [CACHE_DEPTH];
   bit                cache_used [CACHE_DEPTH];
   int unsigned       cache_age  [CACHE_DEPTH];
   int unsigned       cache_fill;
   logic [4:0]        cache_limit;
   lookup_result_type pending_lookups [$];
   int                mismatch_count = 0;

   function automatic int unsigned limit_in_use(logic [4:0] lim);
      if (lim == 5'd0) return 1;
      if (lim > CACHE_DEPTH) return CACHE_DEPTH;
      return {27'd0, lim};
   endfunction

   function automatic int lookup_slot(logic [31:0] k);
      for (int i = 0; i < CACHE_DEPTH; i++)
         if (cache_used[i] && cache_key[i] == k) return i;
      return -1;
   endfunction

   function automatic void unlink_slot(int s);
      int unsigned r;
      r = cache_age[s];
      for (int j = 0; j < CACHE_DEPTH; j++)
         if (cache_used[j] && j != s && cache_age[j] > r) cache_age[j]--;
      cache_used[s] = 1'b0;
      cache_age[s]  = 0;
      if (cache_fill > 0) cache_fill--;
   endfunction

   function automatic void link_front(logic [31:0] k, logic [31:0] v);
      int s;
      s = -1;
      for (int j = 0; j < CACHE_DEPTH; j++)
         if (!cache_used[j] && s < 0) s = j;
      if (s < 0) return;
      for (int j = 0; j < CACHE_DEPTH; j++)
         if (cache_used[j]) cache_age[j]++;
      cache_key[s]  = k;
      cache_data[s] = v;
      cache_used[s] = 1'b1;
      cache_age[s]  = 0;
      cache_fill++;
   endfunction

   function automatic void evict_oldest();
      int          s;
      int unsigned best;
      s    = -1;
      best = 0;
      for (int j = 0; j < CACHE_DEPTH; j++)
         if (cache_used[j] && (s < 0 || cache_age[j] > best)) begin
            s    = j;
            best = cache_age[j];
         end
      if (s >= 0) unlink_slot(s);
   endfunction

   function automatic void clear_cache();
      for (int j = 0; j < CACHE_DEPTH; j++) begin
         cache_used[j] = 1'b0;
         cache_age[j]  = 0;
      end
      cache_fill  = 0;
      cache_limit = 5'd16;
   endfunction

   // Returns 1 when the request produces a response.
   function automatic bit apply_request(logic cmd, logic [31:0] k, logic [31:0] v,
                                        output lookup_result_type res);
      int          s;
      logic [31:0] found;
      s   = lookup_slot(k);
      res = '{hit: 1'b0, value: lkvc_pkg::MISS_VALUE};
      if (cmd == lkvc_pkg::CMD_GET) begin
         if (s >= 0) begin
            found = cache_data[s];
            unlink_slot(s);
            link_front(k, found);
            res = '{hit: 1'b1, value: found};
         end
         return 1'b1;
      end
      if (s >= 0) unlink_slot(s);
      else if (cache_fill >= limit_in_use(cache_limit)) evict_oldest();
      link_front(k, v);
      return 1'b0;
   endfunction

   // ---------------------------------------------------------------- helpers
   task automatic report_mismatch(string what);
      $display("MISMATCH @%0t: %s", $time, what);
      mismatch_count++;
   endtask

   function automatic int draw_wait(inout bit calm);
      if ($urandom_range(0, 29) == 0) calm = !calm;
      return calm ? 0 : $urandom_range(0, 18);
   endfunction

   bit req_calm = 1'b0;

   // Enter and leave at a falling edge.
   task automatic send_request(logic cmd, logic [31:0] k, logic [31:0] v,
                               logic typed, lookup_result_type typed_res);
      int                gap;
      lookup_result_type res;
      gap = draw_wait(req_calm);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_command <= cmd;
      req_key     <= k;
      req_value   <= v;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (apply_request(cmd, k, v, res))
         pending_lookups.push_back(typed ? typed_res : res);
      @(negedge clock);
   endtask

   task automatic write_capacity(logic [4:0] cap);
      req_valid <= 1'b0;
      while (pending_lookups.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      psel    <= 1'b1;
      pwrite  <= 1'b1;
      penable <= 1'b0;
      paddr   <= lkvc_pkg::CSR_ADDR_CAPACITY;
      pwdata  <= {27'd0, cap};
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      cache_limit = cap;
      @(negedge clock);
      pwrite  <= 1'b0;
      penable <= 1'b0;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if (prdata !== {27'd0, cap})
         report_mismatch($sformatf("capacity readback %h, wrote %0d", prdata, cap));
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // ---------------------------------------------------------------- stimulus
   directed_row_type directed_rows [N_DIRECTED] = '{
      '{ROW_REQ, lkvc_pkg::CMD_GET, 32'h0000_0000, 32'h0, 1'b1, 1'b0, lkvc_pkg::MISS_VALUE},
      '{ROW_REQ, lkvc_pkg::CMD_GET, 32'h8000_0000, 32'h0, 1'b1, 1'b0, lkvc_pkg::MISS_VALUE},
      '{ROW_REQ, lkvc_pkg::CMD_PUT, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 1'b0, 32'h0},
      '{ROW_REQ, lkvc_pkg::CMD_PUT, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 1'b0, 32'h0},
      '{ROW_REQ, lkvc_pkg::CMD_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0},
      '{ROW_REQ, lkvc_pkg::CMD_PUT, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, 32'h0},
      '{ROW_REQ, lkvc_pkg::CMD_GET, 32'h8000_0000, 32'h0, 1'b1, 1'b1, 32'h7FFF_FFFF},
      '{ROW_REQ, lkvc_pkg::CMD_GET, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 32'h8000_0000},
      '{ROW_REQ, lkvc_pkg::CMD_GET, 32'hFFFF_FFFF, 32'h0, 1'b1, 1'b1, 32'hFFFF_FFFF},
      '{ROW_REQ, lkvc_pkg::CMD_GET, 32'h0000_0000, 32'h5555_AAAA, 1'b1, 1'b1, 32'h0000_0000},
      '{ROW_REQ, lkvc_pkg::CMD_PUT, 32'h7FFF_FFFF, 32'h1234_5678, 1'b0, 1'b0, 32'h0},
      '{ROW_REQ, lkvc_pkg::CMD_GET, 32'h7FFF_FFFF, 32'h0, 1'b1, 1'b1, 32'h1234_5678},
      '{ROW_REQ, lkvc_pkg::CMD_GET, 32'h7FFF_FFFE, 32'h0, 1'b1, 1'b0, lkvc_pkg::MISS_VALUE},
      '{ROW_REQ, lkvc_pkg::CMD_GET, 32'hFFFF_FFFE, 32'hFFFFFFFF, 1'b1, 1'b0,
        lkvc_pkg::MISS_VALUE},
      '{ROW_CFG, lkvc_pkg::CMD_GET, 32'h0000_0000, 32'd0,         1'b0, 1'b0, 32'h0},
      '{ROW_REQ, lkvc_pkg::CMD_PUT, 32'h0000_0005, 32'd55,        1'b0, 1'b0, 32'h0},
      '{ROW_REQ, lkvc_pkg::CMD_PUT, 32'h0000_0006, 32'd66,        1'b0, 1'b0, 32'h0},
      '{ROW_REQ, lkvc_pkg::CMD_GET, 32'h0000_0006, 32'h0000_0000, 1'b1, 1'b1, 32'd66},
      '{ROW_REQ, lkvc_pkg::CMD_GET, 32'h0000_0005, 32'h0000_0000, 1'b0, 1'b0, 32'h0},
      '{ROW_REQ, lkvc_pkg::CMD_GET, 32'h8000_0000, 32'h0000_0000, 1'b0, 1'b0, 32'h0},
      '{ROW_CFG, lkvc_pkg::CMD_GET, 32'h0000_0000, 32'd31,        1'b0, 1'b0, 32'h0},
      '{ROW_REQ, lkvc_pkg::CMD_PUT, 32'hA5A5_5A5A, 32'hDEAD_BEEF, 1'b0, 1'b0, 32'h0},
      '{ROW_REQ, lkvc_pkg::CMD_GET, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, 32'h0},
      '{ROW_REQ, lkvc_pkg::CMD_GET, 32'hA5A5_5A5A, 32'h0000_0000, 1'b0, 1'b0, 32'h0}
   };

   logic [4:0]  phase_caps  [N_PHASES] = '{5'd1, 5'd16, 5'd2, 5'd0, 5'd31,
                                           5'd17, 5'd3, 5'd8, 5'd16, 5'd5};
   logic [31:0] corner_keys [4] = '{32'h8000_0000, 32'h7FFF_FFFF,
                                    32'h0000_0000, 32'hFFFF_FFFF};

   initial begin : request_side
      logic [31:0]       key_pool [POOL_SIZE];
      int                pool_n;
      int                pick;
      logic [31:0]       k;
      lookup_result_type typed_res;
      clear_cache();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_CFG) begin
            write_capacity(directed_rows[i].value[4:0]);
         end else begin
            typed_res = '{hit: directed_rows[i].exp_hit, value: directed_rows[i].exp_value};
            send_request(directed_rows[i].command, directed_rows[i].key,
                         directed_rows[i].value, directed_rows[i].typed, typed_res);
         end
      end

      for (int p = 0; p < N_PHASES; p++) begin
         write_capacity(phase_caps[p]);
         foreach (key_pool[j]) key_pool[j] = $urandom;
         pool_n = limit_in_use(phase_caps[p]) + $urandom_range(1, 6);
         if (pool_n > POOL_SIZE) pool_n = POOL_SIZE;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 85) k = key_pool[$urandom_range(0, pool_n - 1)];
            else if (pick < 95) k = $urandom;
            else k = corner_keys[$urandom_range(0, 3)];
            send_request(1'($urandom_range(0, 1)), k, $urandom, 1'b0, typed_res);
         end
      end

      req_valid <= 1'b0;
      while (pending_lookups.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_lookups.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

   initial begin : response_side
      int                stall;
      bit                calm;
      lookup_result_type want;
      calm = 1'b0;
      wait (!reset);
      forever begin
         stall = draw_wait(calm);
         @(negedge clock);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         if (pending_lookups.size() == 0) begin
            report_mismatch($sformatf("unexpected response hit=%0b value=%h",
                                      rsp_hit, rsp_read_value));
         end else begin
            want = pending_lookups.pop_front();
            if (rsp_hit !== want.hit)
               report_mismatch($sformatf("hit %b, expected %b", rsp_hit, want.hit));
            if (rsp_read_value !== want.value)
               report_mismatch($sformatf("read_value %h, expected %h",
                                         rsp_read_value, want.value));
         end
      end
   end

endmodule

// File: lru_key_value_cache_core.f
rtl/core/lkvc_pkg.sv
rtl/core/lkvc_store.sv
rtl/core/lru_key_value_cache_core.sv
tb/sv/tb_lru_key_value_cache_core.sv
